// ===== design/ordered_array_table_macros.svh =====
// assertion macros used by the checker file
`ifndef ORDERED_ARRAY_TABLE_MACROS_SVH
`define ORDERED_ARRAY_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define OAT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define OAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/oat_pkg.sv =====
// shared types and codes of the ordered array table
`timescale 1ns / 1ps
`default_nettype none

package oat_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned STAT_W = 3;

  localparam logic [KIND_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [KIND_W-1:0] REQ_INSERT = 3'd1;
  localparam logic [KIND_W-1:0] REQ_WRITE  = 3'd2;
  localparam logic [KIND_W-1:0] REQ_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] REQ_READ   = 3'd4;
  localparam logic [KIND_W-1:0] REQ_SEARCH = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] read_word;
    logic [POS_W-1:0]         found_position;
    logic [CNT_W-1:0]         element_count;
    logic                     empty_flag;
    logic                     full_flag;
  } res_t;

endpackage

`default_nettype wire

// ===== design/oat_ifs.sv =====
// request and response channel interfaces of the ordered array table
`timescale 1ns / 1ps
`default_nettype none

interface oat_req_if import oat_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        req_type;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] data_word;

  modport source (output valid, req_type, position, data_word, input ready);
  modport sink (input valid, req_type, position, data_word, output ready);
endinterface

interface oat_rsp_if import oat_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] read_word;
  logic [POS_W-1:0]         found_position;
  logic [CNT_W-1:0]         element_count;
  logic                     empty_flag;
  logic                     full_flag;

  modport source (
    output valid, status, read_word, found_position, element_count, empty_flag, full_flag,
    input ready
  );
  modport sink (
    input valid, status, read_word, found_position, element_count, empty_flag, full_flag,
    output ready
  );
endinterface

`default_nettype wire

// ===== design/oat_ram.sv =====
// word store: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none

module oat_ram import oat_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [$clog2(DEPTH)-1:0]     waddr_i,
  input  wire logic signed [DATA_W-1:0]     wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]     raddr_i,
  output      logic signed [DATA_W-1:0]     rdata_o
);

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/oat_seq.sv =====
// request sequencer: checks, shift walk, search walk over the word store
`timescale 1ns / 1ps
`default_nettype none

module oat_seq import oat_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         req_valid_i,
  output      logic                         req_ready_o,
  input  wire logic [KIND_W-1:0]            req_type_i,
  input  wire logic [POS_W-1:0]             req_position_i,
  input  wire logic signed [DATA_W-1:0]     req_data_word_i,
  output      logic                         done_o,
  input  wire logic                         ack_i,
  output      res_t                         res_o,
  output      logic                         ram_we_o,
  output      logic [$clog2(DEPTH)-1:0]     ram_waddr_o,
  output      logic signed [DATA_W-1:0]     ram_wdata_o,
  output      logic [$clog2(DEPTH)-1:0]     ram_raddr_o,
  input  wire logic signed [DATA_W-1:0]     ram_rdata_i
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_SRCH,
    S_RDW,
    S_DONE
  } state_e;

  state_e                   state_q;
  logic [CW-1:0]            count_q;
  logic [CW-1:0]            ptr_q;
  logic                     pend_q;
  logic [IW-1:0]            wa_q;
  logic [POS_W-1:0]         pos_q;
  logic signed [DATA_W-1:0] word_q;
  logic [STAT_W-1:0]        status_q;
  logic signed [DATA_W-1:0] rd_q;
  logic [POS_W-1:0]         fpos_q;

  logic          full;
  logic          empty;
  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] pos_in_ext;
  logic [PW-1:0] pos_q_ext;
  logic [PW-1:0] ptr_ext;
  logic          ins_bad;
  logic          pos_bad;
  logic          match;
  logic          del_more;

  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);
  assign cnt_ext    = PW'(count_q);
  assign pos_in_ext = PW'(req_position_i);
  assign pos_q_ext  = PW'(pos_q);
  assign ptr_ext    = PW'(ptr_q);
  assign ins_bad    = (pos_in_ext > cnt_ext);
  assign pos_bad    = (pos_in_ext >= cnt_ext);
  assign match      = pend_q && (ram_rdata_i == word_q);
  assign del_more   = ((ptr_q + CW'(1)) < count_q);

  assign req_ready_o = (state_q == S_IDLE);
  assign done_o      = (state_q == S_DONE);

  always_comb begin
    res_o.status         = status_q;
    res_o.read_word      = rd_q;
    res_o.found_position = fpos_q;
    res_o.element_count  = CNT_W'(count_q);
    res_o.empty_flag     = empty;
    res_o.full_flag      = full;
  end

  // store port control
  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = wa_q;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = IW'(ptr_q);
    unique case (state_q)
      S_IDLE: begin
        ram_wdata_o = req_data_word_i;
        ram_raddr_o = IW'(pos_in_ext);
        if (req_valid_i) begin
          if (req_type_i == REQ_APPEND && !full) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = IW'(count_q);
          end else if (req_type_i == REQ_WRITE && !empty && !pos_bad) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = IW'(pos_in_ext);
          end
        end
      end
      S_INS: begin
        if (ptr_ext > pos_q_ext) begin
          ram_raddr_o = IW'(ptr_q - CW'(1));
        end
        if (pend_q) begin
          ram_we_o = 1'b1;
        end else if (ptr_ext == pos_q_ext) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = IW'(pos_q_ext);
          ram_wdata_o = word_q;
        end
      end
      S_DEL: begin
        ram_raddr_o = IW'(ptr_q + CW'(1));
        ram_we_o    = pend_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
      wa_q     <= '0;
      pos_q    <= '0;
      word_q   <= '0;
      status_q <= ST_OK;
      rd_q     <= '0;
      fpos_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            pos_q    <= req_position_i;
            word_q   <= req_data_word_i;
            rd_q     <= '0;
            fpos_q   <= '0;
            status_q <= ST_OK;
            pend_q   <= 1'b0;
            state_q  <= S_DONE;
            unique case (req_type_i)
              REQ_APPEND: begin
                if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  count_q <= count_q + CW'(1);
                end
              end
              REQ_INSERT: begin
                if (ins_bad) begin
                  status_q <= ST_BADPOS;
                end else if (full) begin
                  status_q <= ST_FULL;
                end else begin
                  ptr_q   <= count_q;
                  state_q <= S_INS;
                end
              end
              REQ_WRITE, REQ_DELETE, REQ_READ: begin
                if (empty) begin
                  status_q <= ST_EMPTY;
                end else if (pos_bad) begin
                  status_q <= ST_BADPOS;
                end else if (req_type_i == REQ_DELETE) begin
                  ptr_q   <= CW'(pos_in_ext);
                  state_q <= S_DEL;
                end else if (req_type_i == REQ_READ) begin
                  state_q <= S_RDW;
                end
              end
              REQ_SEARCH: begin
                ptr_q   <= '0;
                state_q <= S_SRCH;
              end
              default: begin
              end
            endcase
          end
        end
        // walk down from the end, moving each word up by one
        S_INS: begin
          if (ptr_ext > pos_q_ext) begin
            wa_q   <= IW'(ptr_q);
            pend_q <= 1'b1;
            ptr_q  <= ptr_q - CW'(1);
          end else if (pend_q) begin
            pend_q <= 1'b0;
          end else begin
            count_q <= count_q + CW'(1);
            state_q <= S_DONE;
          end
        end
        // walk up from the hole, moving each word down by one
        S_DEL: begin
          if (del_more) begin
            wa_q   <= IW'(ptr_q);
            pend_q <= 1'b1;
            ptr_q  <= ptr_q + CW'(1);
          end else if (pend_q) begin
            pend_q <= 1'b0;
          end else begin
            count_q <= count_q - CW'(1);
            state_q <= S_DONE;
          end
        end
        // compare one stored word per cycle, first match wins
        S_SRCH: begin
          if (match) begin
            fpos_q  <= POS_W'(wa_q);
            pend_q  <= 1'b0;
            state_q <= S_DONE;
          end else if (ptr_q < count_q) begin
            wa_q   <= IW'(ptr_q);
            pend_q <= 1'b1;
            ptr_q  <= ptr_q + CW'(1);
          end else if (pend_q) begin
            pend_q <= 1'b0;
          end else begin
            status_q <= ST_NOTFOUND;
            state_q  <= S_DONE;
          end
        end
        S_RDW: begin
          rd_q    <= ram_rdata_i;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (ack_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/ordered_array_table.sv =====
// ordered array table: top level with sequencer, word store and output register
//
// usage: one request word on req_i (req_type, position, data_word) gives one
// response word on rsp_o (status, read_word, found_position, element_count,
// empty_flag, full_flag). both channels move a word when valid and ready are high.
// req_i.ready is high only while the sequencer is idle; one request at a time.
// append, overwrite, rejected requests and unused codes finish without a walk;
// read waits for the registered store read; insert shifts the words from position
// to the end up by one, delete shifts the words behind position down by one, and
// search compares stored words from position 0 until a match or the end. the store
// has one read and one write port and the shift or compare walk moves one word per
// cycle. the sequencer goes back to idle once the output register takes the
// response, and only then is the next request taken; the longest request is a
// failed search of a full table.
// the response sits in an output register; a stalled receiver holds rsp_o, and a
// finished request waits in the sequencer until the register frees up, so the
// next request is taken only once its response is in the register.
// reset clears the element count; stored words are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_table import oat_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  oat_req_if.sink    req_i,
  oat_rsp_if.source  rsp_o
);

  localparam int unsigned IW = $clog2(DEPTH);

  logic                     done;
  logic                     ack;
  res_t                     res;
  logic                     ram_we;
  logic [IW-1:0]            ram_waddr;
  logic signed [DATA_W-1:0] ram_wdata;
  logic [IW-1:0]            ram_raddr;
  logic signed [DATA_W-1:0] ram_rdata;

  logic out_valid_q;
  res_t out_q;

  oat_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_i.valid),
    .req_ready_o     (req_i.ready),
    .req_type_i      (req_i.req_type),
    .req_position_i  (req_i.position),
    .req_data_word_i (req_i.data_word),
    .done_o          (done),
    .ack_i           (ack),
    .res_o           (res),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata)
  );

  oat_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register takes the result when empty or being drained
  assign ack = done && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else if (ack) begin
      out_valid_q <= 1'b1;
      out_q       <= res;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_q.status;
  assign rsp_o.read_word      = out_q.read_word;
  assign rsp_o.found_position = out_q.found_position;
  assign rsp_o.element_count  = out_q.element_count;
  assign rsp_o.empty_flag     = out_q.empty_flag;
  assign rsp_o.full_flag      = out_q.full_flag;

endmodule

`default_nettype wire

// ===== design/oat_checker.sv =====
// port-level assertions of the ordered array table and their bind
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_array_table_macros.svh"

module oat_checker import oat_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     req_valid_i,
  input wire logic                     req_ready_i,
  input wire logic                     rsp_valid_i,
  input wire logic                     rsp_ready_i,
  input wire logic [STAT_W-1:0]        rsp_status_i,
  input wire logic signed [DATA_W-1:0] rsp_read_word_i,
  input wire logic [POS_W-1:0]         rsp_found_position_i,
  input wire logic                     rsp_empty_flag_i,
  input wire logic                     rsp_full_flag_i
);

  `OAT_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "response word dropped while stalled")

  `OAT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request taken while previous request still in work")

  `OAT_ASSERT_NOW(a_flags_exclusive, clk_i, rst_ni, rsp_valid_i && rsp_full_flag_i, !rsp_empty_flag_i, "table reported both empty and full")

  `OAT_ASSERT_NOW(a_reject_zero, clk_i, rst_ni, rsp_valid_i && (rsp_status_i != ST_OK), (rsp_read_word_i == 0) && (rsp_found_position_i == '0), "rejected request carries read or search data")

  `OAT_ASSERT_NOW(a_status_flags, clk_i, rst_ni, rsp_valid_i && ((rsp_status_i == ST_FULL && !rsp_full_flag_i) || (rsp_status_i == ST_EMPTY && !rsp_empty_flag_i)), 1'b0, "status disagrees with empty or full flag")

endmodule

bind ordered_array_table oat_checker u_oat_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .req_valid_i          (req_i.valid),
  .req_ready_i          (req_i.ready),
  .rsp_valid_i          (rsp_o.valid),
  .rsp_ready_i          (rsp_o.ready),
  .rsp_status_i         (rsp_o.status),
  .rsp_read_word_i      (rsp_o.read_word),
  .rsp_found_position_i (rsp_o.found_position),
  .rsp_empty_flag_i     (rsp_o.empty_flag),
  .rsp_full_flag_i      (rsp_o.full_flag)
);

`default_nettype wire

// ===== dv/ordered_array_table_test.sv =====
`timescale 1ns / 1ps
// testbench for the ordered array table: random and directed requests against a mirrored word table
module ordered_array_table_test;
  import oat_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam logic [KIND_W-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [KIND_W-1:0] REQ_SPARE7 = 3'd7;
  localparam int TREND_GROW = 0;
  localparam int TREND_SHRINK = 1;
  localparam int TREND_MIXED = 2;
  localparam int unsigned ITEMS_PER_PHASE = 400;
  localparam int unsigned DRAIN_CYCLES = 2 * (DEPTH + 4);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned REPORT_LIMIT = 10;

  class word_table_mirror;
    logic signed [DATA_W-1:0] words [DEPTH];
    int unsigned fill;
    res_t pending_responses [$];
    int unsigned failures;

    function new();
      fill = 0;
      failures = 0;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] word);
      res_t r;
      int unsigned i;
      r = '0;
      r.status = ST_OK;
      case (kind)
        REQ_APPEND: begin
          if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            words[fill] = word;
            fill++;
          end
        end
        REQ_INSERT: begin
          if (pos > fill) begin
            r.status = ST_BADPOS;
          end else if (fill >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = fill; i > pos; i--) words[i] = words[i-1];
            words[pos] = word;
            fill++;
          end
        end
        REQ_WRITE, REQ_DELETE, REQ_READ: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (pos >= fill) begin
            r.status = ST_BADPOS;
          end else if (kind == REQ_WRITE) begin
            words[pos] = word;
          end else if (kind == REQ_DELETE) begin
            for (i = pos; i + 1 < fill; i++) words[i] = words[i+1];
            fill--;
          end else begin
            r.read_word = words[pos];
          end
        end
        REQ_SEARCH: begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < fill; i++) begin
            if (words[i] == word) begin
              r.status = ST_OK;
              r.found_position = i[POS_W-1:0];
              break;
            end
          end
        end
        default: begin
        end
      endcase
      r.element_count = fill[CNT_W-1:0];
      r.empty_flag = (fill == 0);
      r.full_flag = (fill >= DEPTH);
      pending_responses.push_back(r);
    endfunction

    function void check_response(res_t got);
      res_t want;
      if (pending_responses.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("unexpected response word: status %0d count %0d", got.status,
                   got.element_count);
        return;
      end
      want = pending_responses.pop_front();
      if (got.status !== want.status || got.read_word !== want.read_word ||
          got.found_position !== want.found_position ||
          got.element_count !== want.element_count ||
          got.empty_flag !== want.empty_flag || got.full_flag !== want.full_flag) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("response mismatch at %0t: expected status %0d read %0d found %0d ",
                   $time, want.status, want.read_word, want.found_position,
                   "count %0d empty %0b full %0b, got status %0d read %0d found %0d ",
                   want.element_count, want.empty_flag, want.full_flag,
                   got.status, got.read_word, got.found_position,
                   "count %0d empty %0b full %0b",
                   got.element_count, got.empty_flag, got.full_flag);
      end
    endfunction

    function logic signed [DATA_W-1:0] stored_word();
      return words[$urandom_range(fill - 1)];
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycles = 0;
  word_table_mirror mirror;

  oat_req_if req_ch ();
  oat_rsp_if rsp_ch ();

  ordered_array_table #(.DEPTH(DEPTH)) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_ch.sink),
    .rsp_o (rsp_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : response_monitor
    res_t got;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got.status = rsp_ch.status;
      got.read_word = rsp_ch.read_word;
      got.found_position = rsp_ch.found_position;
      got.element_count = rsp_ch.element_count;
      got.empty_flag = rsp_ch.empty_flag;
      got.full_flag = rsp_ch.full_flag;
      mirror.check_response(got);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic push_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.position <= pos;
    req_ch.data_word <= word;
    do @(posedge clk); while (!req_ch.ready);
    mirror.note_request(kind, pos, word);
    @(negedge clk);
  endtask

  function automatic logic [KIND_W-1:0] pick_kind(int trend);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 2) return (r == 0) ? REQ_SPARE6 : REQ_SPARE7;
    case (trend)
      TREND_GROW: begin
        if (r < 42) return REQ_APPEND;
        if (r < 80) return REQ_INSERT;
        if (r < 84) return REQ_DELETE;
        if (r < 89) return REQ_WRITE;
        if (r < 94) return REQ_READ;
        return REQ_SEARCH;
      end
      TREND_SHRINK: begin
        if (r < 55) return REQ_DELETE;
        if (r < 63) return REQ_APPEND;
        if (r < 70) return REQ_INSERT;
        if (r < 78) return REQ_WRITE;
        if (r < 88) return REQ_READ;
        return REQ_SEARCH;
      end
      default: begin
        if (r < 18) return REQ_APPEND;
        if (r < 34) return REQ_INSERT;
        if (r < 50) return REQ_DELETE;
        if (r < 66) return REQ_WRITE;
        if (r < 82) return REQ_READ;
        return REQ_SEARCH;
      end
    endcase
  endfunction

  function automatic logic [POS_W-1:0] pick_position(logic [KIND_W-1:0] kind);
    int unsigned fill;
    fill = mirror.fill;
    if ($urandom_range(99) < 15) return POS_W'($urandom_range(15));
    if (kind == REQ_INSERT)
      return (fill > 15) ? POS_W'($urandom_range(15)) : POS_W'($urandom_range(fill));
    if (fill == 0) return POS_W'($urandom_range(15));
    return POS_W'($urandom_range(fill - 1));
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_word(logic [KIND_W-1:0] kind);
    int unsigned r;
    r = $urandom_range(99);
    if (mirror.fill != 0 && ((kind == REQ_SEARCH) ? (r < 65) : (r < 10)))
      return mirror.stored_word();
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(4))
        0: return -1;
        1: return 0;
        2: return 32'sh8000_0000;
        3: return 32'sh7fff_ffff;
        default: return $urandom_range(3);
      endcase
    end
    return $urandom();
  endfunction

  task automatic run_directed();
    push_request(REQ_SEARCH, 4'd0, 0);
    push_request(REQ_READ, 4'd0, 0);
    push_request(REQ_WRITE, 4'd15, 32'sh0000_1234);
    push_request(REQ_DELETE, 4'd0, 0);
    push_request(REQ_INSERT, 4'd1, 0);
    push_request(REQ_INSERT, 4'd0, 32'sh8000_0000);
    push_request(REQ_APPEND, 4'd0, 32'sh7fff_ffff);
    repeat (DEPTH - 2)
      push_request(REQ_APPEND, POS_W'($urandom_range(15)), pick_word(REQ_APPEND));
    push_request(REQ_APPEND, 4'd0, -1);
    push_request(REQ_INSERT, 4'd15, 0);
    push_request(REQ_READ, 4'd15, 0);
    push_request(REQ_SEARCH, 4'd0, 32'sh7fff_ffff);
    push_request(REQ_DELETE, 4'd15, 0);
    push_request(REQ_WRITE, 4'd15, -1);
    push_request(REQ_READ, 4'd15, 0);
    push_request(REQ_SPARE6, 4'd15, -1);
    push_request(REQ_SPARE7, 4'd0, 0);
  endtask

  // segments that mostly grow, mostly shrink or mix, so the table swings between empty and full
  task automatic run_random(int unsigned items);
    int trend;
    int unsigned seg;
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0] pos;
    seg = 0;
    trend = TREND_MIXED;
    repeat (items) begin
      if (seg == 0) begin
        trend = $urandom_range(TREND_MIXED);
        seg = $urandom_range(40, 16);
      end
      seg--;
      kind = pick_kind(trend);
      pos = pick_position(kind);
      push_request(kind, pos, pick_word(kind));
    end
  endtask

  initial begin
    mirror = new();
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_APPEND;
    req_ch.position = '0;
    req_ch.data_word = '0;
    rsp_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 29;
    recv_idle_pct = 59;
    run_directed();
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      run_random(ITEMS_PER_PHASE);
    end
    req_ch.valid <= 1'b0;
    while (mirror.pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.failures == 0 && mirror.pending_responses.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/oat_pkg.sv
design/oat_ifs.sv
design/oat_ram.sv
design/oat_seq.sv
design/ordered_array_table.sv
design/oat_checker.sv
dv/ordered_array_table_test.sv
